[rtl/brss_pkg.sv]
`default_nettype none

package brss_pkg;

    // Default sizes
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int ABS_TOL_W     = 31;
    localparam int REL_TOL_W     = 16;
    localparam int RES_TOL_W     = 31;
    localparam int BUDGET_W      = 16;
    localparam int CALLS_W       = 16;
    localparam int REL_FRAC_BITS = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_ABS_TOL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REL_TOL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RES_TOL = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUDGET  = 2'd3;

    localparam logic [ABS_TOL_W-1:0] ABS_TOL_RST = 31'd1;
    localparam logic [REL_TOL_W-1:0] REL_TOL_RST = 16'd1;
    localparam logic [RES_TOL_W-1:0] RES_TOL_RST = 31'd1;
    localparam logic [BUDGET_W-1:0]  BUDGET_RST  = 16'd100;

    // Input operation
    localparam logic OP_START = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef logic [1:0] status_t;

    localparam status_t ST_EVALUATE  = 2'd0;
    localparam status_t ST_FINISHED  = 2'd1;
    localparam status_t ST_NO_SIGN   = 2'd2;
    localparam status_t ST_IDLE_EVAL = 2'd3;

endpackage

`default_nettype wire

[rtl/bisection_root_search_sequencer.sv]
`default_nettype none
// Bisection root search sequencer.
// Dataflow: an input transfer loads the input register; the result register is loaded
// from it when the result register is empty or its output is not stalled.
// Throughput: one item per cycle while the output is not stalled; the bracket update, midpoint and tolerance multiply
// sit in one combinational stage between the input and result registers.
// Reset (rst_n, async, active low): idle, state cleared, configuration registers at their defaults.
module bisection_root_search_sequencer #(
    parameter int DATA_WIDTH  = brss_pkg::DATA_WIDTH_DEF,
    parameter int COUNT_WIDTH = brss_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,

    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [brss_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire [brss_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire                                   op,
    input  wire signed [DATA_WIDTH-1:0]           point_low,
    input  wire signed [DATA_WIDTH-1:0]           point_high,
    input  wire signed [DATA_WIDTH-1:0]           value_at_low,
    input  wire signed [DATA_WIDTH-1:0]           value_at_high,
    input  wire signed [DATA_WIDTH-1:0]           target,
    input  wire signed [DATA_WIDTH-1:0]           function_value,

    output logic                                  out_valid,
    input  wire                                   out_stall,
    output brss_pkg::status_t                     status,
    output logic signed [DATA_WIDTH-1:0]          point,
    output logic [brss_pkg::CALLS_W-1:0]          calls_used
);
    import brss_pkg::*;

    localparam int DW       = DATA_WIDTH;
    localparam int RES_CMP_W = (DW > RES_TOL_W) ? DW : RES_TOL_W;
    localparam int TOL_W    = ((DW > ABS_TOL_W) ? DW : ABS_TOL_W) + 1;
    localparam int CNT_CMP_W = (COUNT_WIDTH > BUDGET_W) ? COUNT_WIDTH : BUDGET_W;
    localparam int PROD_W   = REL_TOL_W + DW;

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
        logic [DW-1:0] n;
        n = ~v + 1'b1;
        return v[DW-1] ? n : v;
    endfunction

    // v - t, saturated to DW bits
    function automatic logic [DW-1:0] sat_sub(input logic [DW-1:0] v, input logic [DW-1:0] t);
        logic [DW:0] d;
        d = {v[DW-1], v} - {t[DW-1], t};
        if (d[DW] != d[DW-1])
            return d[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        return d[DW-1:0];
    endfunction

    // configuration registers
    logic [ABS_TOL_W-1:0] abs_tol_reg;
    logic [REL_TOL_W-1:0] rel_tol_reg;
    logic [RES_TOL_W-1:0] res_tol_reg;
    logic [BUDGET_W-1:0]  budget_reg;

    // input register
    logic          s1_valid_reg;
    logic          s1_op_reg;
    logic [DW-1:0] s1_low_reg;
    logic [DW-1:0] s1_high_reg;
    logic [DW-1:0] s1_val_low_reg;
    logic [DW-1:0] s1_val_high_reg;
    logic [DW-1:0] s1_target_reg;
    logic [DW-1:0] s1_fval_reg;

    // search state
    logic [DW-1:0]          bracket_low_reg,  bracket_low_next;
    logic [DW-1:0]          bracket_high_reg, bracket_high_next;
    logic                   low_pos_reg,      low_pos_next;
    logic [DW-1:0]          midpoint_reg,     midpoint_next;
    logic [DW-1:0]          target_reg,       target_next;
    logic [COUNT_WIDTH-1:0] call_count_reg,   call_count_next;
    logic                   searching_reg,    searching_next;

    // result register
    logic                   out_valid_reg;
    status_t                status_reg;
    logic [DW-1:0]          point_reg;
    logic [CALLS_W-1:0]     calls_reg;

    logic s1_fire;
    logic in_xfer;

    assign cfg_ready  = 1'b1;
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_fire;
    assign in_xfer    = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign point      = point_reg;
    assign calls_used = calls_reg;

    // residuals and end tests
    logic [DW-1:0] res_a, res_b, res_c;
    logic          root_a, root_b, root_c;
    logic          a_nonpos, b_nonpos, c_pos;

    always_comb
    begin
        res_a    = sat_sub(s1_val_low_reg, s1_target_reg);
        res_b    = sat_sub(s1_val_high_reg, s1_target_reg);
        res_c    = sat_sub(s1_fval_reg, target_reg);
        root_a   = RES_CMP_W'(mag(res_a)) <= RES_CMP_W'(res_tol_reg);
        root_b   = RES_CMP_W'(mag(res_b)) <= RES_CMP_W'(res_tol_reg);
        root_c   = RES_CMP_W'(mag(res_c)) <= RES_CMP_W'(res_tol_reg);
        a_nonpos = res_a[DW-1] || (res_a == '0);
        b_nonpos = res_b[DW-1] || (res_b == '0);
        c_pos    = !res_c[DW-1] && (res_c != '0);
    end

    // one bisection step, shared by start and evaluation
    logic [DW-1:0]          adv_low, adv_high, adv_prev_mid, adv_mid, adv_delta;
    logic [COUNT_WIDTH-1:0] count_inc, adv_count;
    logic [DW:0]            diff, diff_adj;
    logic [PROD_W-1:0]      prod;
    logic [TOL_W-1:0]       tol;
    logic                   adv_done;

    always_comb
    begin
        count_inc = call_count_reg + 1'b1;
        if (s1_op_reg == OP_START)
        begin
            adv_low      = s1_low_reg;
            adv_high     = s1_high_reg;
            adv_prev_mid = s1_low_reg;
            adv_count    = '0;
        end
        else
        begin
            adv_prev_mid = midpoint_reg;
            adv_count    = count_inc;
            if (c_pos == low_pos_reg)
            begin
                adv_low  = midpoint_reg;
                adv_high = bracket_high_reg;
            end
            else
            begin
                adv_low  = bracket_low_reg;
                adv_high = midpoint_reg;
            end
        end
        // half width, truncated toward zero
        diff      = {adv_high[DW-1], adv_high} - {adv_low[DW-1], adv_low};
        diff_adj  = diff + {{DW{1'b0}}, diff[DW]};
        adv_delta = diff_adj[DW:1];
        adv_mid   = adv_low + adv_delta;
        prod      = PROD_W'(rel_tol_reg) * PROD_W'(mag(adv_prev_mid));
        tol       = TOL_W'(prod[PROD_W-1:REL_FRAC_BITS]) + TOL_W'(abs_tol_reg);
        adv_done  = (TOL_W'(mag(adv_delta)) <= tol)
                 || (CNT_CMP_W'(adv_count) >= CNT_CMP_W'(budget_reg))
                 || (adv_count == '1);
    end

    status_t       res_status;
    logic [DW-1:0] res_point;
    logic [CALLS_W-1:0] res_calls;

    always_comb
    begin
        bracket_low_next  = bracket_low_reg;
        bracket_high_next = bracket_high_reg;
        low_pos_next      = low_pos_reg;
        midpoint_next     = midpoint_reg;
        target_next       = target_reg;
        call_count_next   = call_count_reg;
        searching_next    = searching_reg;
        res_status        = ST_IDLE_EVAL;
        res_point         = '0;
        res_calls         = '0;
        if (s1_op_reg == OP_START)
        begin
            searching_next = 1'b0;
            if (root_a)
            begin
                res_status = ST_FINISHED;
                res_point  = s1_low_reg;
            end
            else if (root_b)
            begin
                res_status = ST_FINISHED;
                res_point  = s1_high_reg;
            end
            else if (a_nonpos == b_nonpos)
            begin
                res_status = ST_NO_SIGN;
            end
            else
            begin
                bracket_low_next  = adv_low;
                bracket_high_next = adv_high;
                low_pos_next      = a_nonpos ? 1'b0 : 1'b1;
                midpoint_next     = adv_mid;
                target_next       = s1_target_reg;
                call_count_next   = '0;
                searching_next    = !adv_done;
                res_status        = adv_done ? ST_FINISHED : ST_EVALUATE;
                res_point         = adv_mid;
            end
        end
        else if (searching_reg)
        begin
            call_count_next = count_inc;
            res_calls       = CALLS_W'(count_inc);
            if (root_c)
            begin
                searching_next = 1'b0;
                res_status     = ST_FINISHED;
                res_point      = midpoint_reg;
            end
            else
            begin
                bracket_low_next  = adv_low;
                bracket_high_next = adv_high;
                midpoint_next     = adv_mid;
                searching_next    = !adv_done;
                res_status        = adv_done ? ST_FINISHED : ST_EVALUATE;
                res_point         = adv_mid;
            end
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_tol_reg <= ABS_TOL_RST;
            rel_tol_reg <= REL_TOL_RST;
            res_tol_reg <= RES_TOL_RST;
            budget_reg  <= BUDGET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ABS_TOL: abs_tol_reg <= cfg_data[ABS_TOL_W-1:0];
                CFG_REL_TOL: rel_tol_reg <= cfg_data[REL_TOL_W-1:0];
                CFG_RES_TOL: res_tol_reg <= cfg_data[RES_TOL_W-1:0];
                CFG_BUDGET:  budget_reg  <= cfg_data[BUDGET_W-1:0];
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            bracket_low_reg  <= '0;
            bracket_high_reg <= '0;
            low_pos_reg      <= 1'b0;
            midpoint_reg     <= '0;
            target_reg       <= '0;
            call_count_reg   <= '0;
            searching_reg    <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                bracket_low_reg  <= bracket_low_next;
                bracket_high_reg <= bracket_high_next;
                low_pos_reg      <= low_pos_next;
                midpoint_reg     <= midpoint_next;
                target_reg       <= target_next;
                call_count_reg   <= call_count_next;
                searching_reg    <= searching_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg       <= op;
            s1_low_reg      <= point_low;
            s1_high_reg     <= point_high;
            s1_val_low_reg  <= value_at_low;
            s1_val_high_reg <= value_at_high;
            s1_target_reg   <= target;
            s1_fval_reg     <= function_value;
        end
        if (s1_fire)
        begin
            status_reg <= res_status;
            point_reg  <= res_point;
            calls_reg  <= res_calls;
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_bisection_root_search_sequencer.sv]
module tb_bisection_root_search_sequencer;
    import brss_pkg::*;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam longint L_MAX = 64'sd2147483647;
    localparam longint L_MIN = -64'sd2147483648;
    localparam int IDLE_LIMIT = 1000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 229;

    typedef struct {
        logic op;
        logic signed [31:0] pl;
        logic signed [31:0] ph;
        logic signed [31:0] vl;
        logic signed [31:0] vh;
        logic signed [31:0] tgt;
        logic signed [31:0] fv;
    } probe_req_t;

    typedef struct {
        status_t st;
        logic signed [31:0] pt;
        logic [15:0] calls;
    } probe_res_t;

    typedef struct {
        probe_req_t req;
        bit typed;
        probe_res_t res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_ABS_TOL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = OP_START;
    logic signed [31:0] point_low = '0;
    logic signed [31:0] point_high = '0;
    logic signed [31:0] value_at_low = '0;
    logic signed [31:0] value_at_high = '0;
    logic signed [31:0] target = '0;
    logic signed [31:0] function_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    status_t status;
    logic signed [31:0] point;
    logic [CALLS_W-1:0] calls_used;

    // shadow of the block: configuration and search state
    logic [ABS_TOL_W-1:0] tol_abs = ABS_TOL_RST;
    logic [REL_TOL_W-1:0] tol_rel = REL_TOL_RST;
    logic [RES_TOL_W-1:0] tol_res = RES_TOL_RST;
    logic [BUDGET_W-1:0] max_evals = BUDGET_RST;
    longint lo_end = 0;
    longint hi_end = 0;
    longint probe = 0;
    longint held_target = 0;
    bit lo_positive = 1'b0;
    logic [15:0] evals = '0;
    bit in_search = 1'b0;

    // the function the search is run against
    logic signed [31:0] fn_tgt = '0;
    longint fn_root = 0;
    int fn_shift = 0;
    bit fn_neg = 1'b0;

    probe_res_t pending_results[$];
    probe_res_t seen_exp;
    dir_row_t dir_rows[$];
    int errors = 0;
    int idle_cycles = 0;
    int gap_odds = 4;
    int stall_odds = 4;
    int stall_left = 0;

    bisection_root_search_sequencer uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .point_low(point_low),
        .point_high(point_high),
        .value_at_low(value_at_low),
        .value_at_high(value_at_high),
        .target(target),
        .function_value(function_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .point(point),
        .calls_used(calls_used)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > L_MAX)
            return Q_MAX;
        if (v < L_MIN)
            return Q_MIN;
        return v[31:0];
    endfunction

    // loop head: halve the bracket, then tolerance and budget tests
    function automatic probe_res_t bisect_next();
        probe_res_t r;
        longint tol;
        longint half;
        tol = ((longint'(tol_rel) * mag(probe)) >>> REL_FRAC_BITS) + longint'(tol_abs);
        half = (hi_end - lo_end) / 2;
        probe = lo_end + half;
        r.pt = probe[31:0];
        r.calls = evals;
        if (mag(half) <= tol || evals >= max_evals || evals == '1)
        begin
            in_search = 1'b0;
            r.st = ST_FINISHED;
        end
        else
            r.st = ST_EVALUATE;
        return r;
    endfunction

    function automatic probe_res_t bisect_step(probe_req_t s);
        probe_res_t r;
        longint fa;
        longint fb;
        longint fc;
        r.st = ST_IDLE_EVAL;
        r.pt = '0;
        r.calls = '0;
        if (s.op == OP_START)
        begin
            fa = longint'(sat32(longint'(s.vl) - longint'(s.tgt)));
            fb = longint'(sat32(longint'(s.vh) - longint'(s.tgt)));
            in_search = 1'b0;
            if (mag(fa) <= longint'(tol_res))
            begin
                r.st = ST_FINISHED;
                r.pt = s.pl;
            end
            else if (mag(fb) <= longint'(tol_res))
            begin
                r.st = ST_FINISHED;
                r.pt = s.ph;
            end
            else if ((fa <= 0) == (fb <= 0))
                r.st = ST_NO_SIGN;
            else
            begin
                lo_end = longint'(s.pl);
                hi_end = longint'(s.ph);
                lo_positive = fa > 0;
                probe = longint'(s.pl);
                held_target = longint'(s.tgt);
                evals = '0;
                in_search = 1'b1;
                r = bisect_next();
            end
        end
        else if (in_search)
        begin
            fc = longint'(sat32(longint'(s.fv) - held_target));
            evals = evals + 16'd1;
            if (mag(fc) <= longint'(tol_res))
            begin
                in_search = 1'b0;
                r.st = ST_FINISHED;
                r.pt = probe[31:0];
                r.calls = evals;
            end
            else
            begin
                if ((fc > 0) == lo_positive)
                    lo_end = probe;
                else
                    hi_end = probe;
                r = bisect_next();
            end
        end
        return r;
    endfunction

    function automatic logic signed [31:0] fval(longint x);
        longint d;
        d = (x - fn_root) >>> fn_shift;
        if (fn_neg)
            d = -d;
        return sat32(longint'(fn_tgt) + d);
    endfunction

    function automatic logic signed [31:0] rand_point();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 2000)) - 1000;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = '0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            default: v = $signed($urandom) >>> $urandom_range(4, 24);
        endcase
        return v;
    endfunction

    // called just after a falling edge; returns just after the falling edge that follows the input transfer
    task automatic send(input probe_req_t s, input bit typed, input probe_res_t res);
        probe_res_t r;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        op = s.op;
        point_low = s.pl;
        point_high = s.ph;
        value_at_low = s.vl;
        value_at_high = s.vh;
        target = s.tgt;
        function_value = s.fv;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = bisect_step(s);
        pending_results.push_back(typed ? res : r);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ABS_TOL: tol_abs = data[ABS_TOL_W-1:0];
            CFG_REL_TOL: tol_rel = data[REL_TOL_W-1:0];
            CFG_RES_TOL: tol_res = data[RES_TOL_W-1:0];
            CFG_BUDGET: max_evals = data[BUDGET_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // unused upper data bits are filled at random
    task automatic load_tolerances(input logic [30:0] a, input logic [15:0] rel,
                                   input logic [30:0] res, input logic [15:0] bud);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        write_reg(CFG_ABS_TOL, {1'($urandom_range(0, 1)), a});
        write_reg(CFG_REL_TOL, {16'($urandom), rel});
        write_reg(CFG_RES_TOL, {1'($urandom_range(0, 1)), res});
        write_reg(CFG_BUDGET, {16'($urandom), bud});
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int n);
        probe_req_t s;
        probe_res_t none;
        longint a;
        longint b;
        longint swap_tmp;
        int k;
        none.st = ST_EVALUATE;
        none.pt = '0;
        none.calls = '0;
        for (k = 0; k < n; k++)
        begin
            s.op = OP_EVAL;
            s.pl = $urandom;
            s.ph = $urandom;
            s.vl = $urandom;
            s.vh = $urandom;
            s.tgt = $urandom;
            s.fv = $urandom;
            if (in_search && $urandom_range(0, 99) < 90)
            begin
                if ($urandom_range(0, 9) != 0)
                    s.fv = fval(probe);
            end
            else if (in_search || $urandom_range(0, 19) != 0)
            begin
                // new search; when busy this abandons the running one
                s.op = OP_START;
                fn_tgt = rand_point();
                fn_shift = $urandom_range(0, 6);
                fn_neg = 1'($urandom_range(0, 1));
                a = longint'(rand_point());
                if ($urandom_range(0, 3) == 0)
                    b = longint'(rand_point());
                else
                    b = longint'(sat32(a + longint'($urandom_range(1,
                                                   1 << $urandom_range(1, 24)))));
                if ($urandom_range(0, 4) == 0)
                    fn_root = longint'(rand_point());
                else
                    fn_root = a + (b - a) / longint'($urandom_range(2, 9));
                if ($urandom_range(0, 6) == 0)
                begin
                    swap_tmp = a;
                    a = b;
                    b = swap_tmp;
                end
                s.pl = a[31:0];
                s.ph = b[31:0];
                s.tgt = fn_tgt;
                if ($urandom_range(0, 9) != 0)
                begin
                    s.vl = fval(a);
                    s.vh = fval(b);
                end
            end
            send(s, 1'b0, none);
        end
    endtask

    task automatic add_row(input logic o, input logic signed [31:0] pl, ph, vl, vh, tgt, fv,
                           input bit typed, input status_t st, input logic signed [31:0] pt,
                           input logic [15:0] calls);
        dir_row_t d;
        d.req.op = o;
        d.req.pl = pl;
        d.req.ph = ph;
        d.req.vl = vl;
        d.req.vh = vh;
        d.req.tgt = tgt;
        d.req.fv = fv;
        d.typed = typed;
        d.res.st = st;
        d.res.pt = pt;
        d.res.calls = calls;
        dir_rows.push_back(d);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
        begin
            out_stall = 1'b1;
            stall_left = $urandom_range(1, 14) - 1;
        end
        else
            out_stall = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: status %0d point %0d calls %0d",
                       status, point, calls_used);
                errors++;
            end
            else
            begin
                seen_exp = pending_results.pop_front();
                if (status !== seen_exp.st)
                begin
                    $error("status: expected %0d, got %0d", seen_exp.st, status);
                    errors++;
                end
                if (point !== seen_exp.pt)
                begin
                    $error("point: expected %0d, got %0d", seen_exp.pt, point);
                    errors++;
                end
                if (calls_used !== seen_exp.calls)
                begin
                    $error("calls_used: expected %0d, got %0d", seen_exp.calls, calls_used);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL bisection_root_search_sequencer");
            $finish;
        end
    end

    initial
    begin
        int i;
        int ph;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // defaults: abs 1, rel 1, residual 1, budget 100
        add_row(OP_EVAL, 0, 0, 0, 0, 0, Q_MAX, 1, ST_IDLE_EVAL, 0, 0);
        // low end already a root
        add_row(OP_START, Q_MIN, Q_MAX, 5, Q_MIN, 5, 0, 1, ST_FINISHED, Q_MIN, 0);
        // low residual saturates, high end within tolerance
        add_row(OP_START, 32'sh100, Q_MAX, 1000, Q_MIN + 1, Q_MIN, -1, 1, ST_FINISHED, Q_MAX, 0);
        add_row(OP_START, 32'sh12345678, 7, -1, 50, 0, 0, 1, ST_FINISHED, 32'sh12345678, 0);
        // no sign change, plain and with saturated residuals
        add_row(OP_START, 10, 20, 2, 3, 0, 0, 1, ST_NO_SIGN, 0, 0);
        add_row(OP_START, 0, 1, Q_MAX, Q_MIN + 2, Q_MIN, 0, 1, ST_NO_SIGN, 0, 0);
        add_row(OP_START, 0, 1, Q_MIN, Q_MAX - 2, Q_MAX, 0, 1, ST_NO_SIGN, 0, 0);
        // short search hitting the root at the first midpoint
        add_row(OP_START, 0, 32'sh100000, -32'sh80000, 32'sh80000, 0, 0,
                1, ST_EVALUATE, 32'sh80000, 0);
        add_row(OP_EVAL, 0, 0, 0, 0, 0, 0, 1, ST_FINISHED, 32'sh80000, 1);
        // full-range bracket
        add_row(OP_START, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0, ST_EVALUATE, 0, 0);
        add_row(OP_EVAL, -1, -1, -1, -1, -1, Q_MAX, 0, ST_EVALUATE, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, 0, 0, Q_MIN, 0, ST_EVALUATE, 0, 0);
        // restart while searching, reversed bracket
        add_row(OP_START, Q_MAX, Q_MIN, 100, -100, 0, 0, 0, ST_EVALUATE, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, 0, 0, -5, 0, ST_EVALUATE, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, 0, 0, 7, 0, ST_EVALUATE, 0, 0);
        // evaluation residuals that saturate
        add_row(OP_START, -32'sh10000, 32'sh10000, 0, Q_MAX, 32'sh40000000, 0,
                0, ST_EVALUATE, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, 0, 0, Q_MIN, 0, ST_EVALUATE, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, 0, 0, Q_MAX, 0, ST_EVALUATE, 0, 0);
        add_row(OP_EVAL, 0, 0, 0, 0, 0, 32'sh40000000, 0, ST_EVALUATE, 0, 0);
        add_row(OP_EVAL, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1, ST_IDLE_EVAL, 0, 0);
        // zero-width bracket finishes at once
        add_row(OP_START, 32'sh5000, 32'sh5000, -10, 10, 0, 0, 1, ST_FINISHED, 32'sh5000, 0);
        add_row(OP_EVAL, -1, -1, -1, -1, -1, -1, 1, ST_IDLE_EVAL, 0, 0);

        for (i = 0; i < dir_rows.size(); i++)
            send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: load_tolerances(31'd0, 16'd0, 31'd0, 16'hFFFF);
                1: load_tolerances(31'h7FFFFFFF, 16'hFFFF, 31'd0, 16'd0);
                2: load_tolerances(31'd0, 16'hFFFF, 31'h7FFFFFFF, 16'hFFFF);
                3: load_tolerances(31'd1, 16'd1, 31'd1, 16'd100);
                4: load_tolerances(31'd0, 16'd0, 31'($urandom_range(0, 15)),
                                   16'($urandom_range(1, 8)));
                default: load_tolerances(31'($urandom_range(0, 1 << $urandom_range(0, 20))),
                                         16'($urandom_range(0, 65535)),
                                         31'($urandom_range(0, 1 << $urandom_range(0, 12))),
                                         16'($urandom_range(0, 40)));
            endcase
            // phase 3 and the closing phase run without any idling
            if (ph == 3 || ph == PHASES - 1)
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds = $urandom_range(2, 10);
                stall_odds = $urandom_range(2, 10);
            end
            run_random(PHASE_ITEMS);
        end
        in_valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS bisection_root_search_sequencer");
        else
            $display("FAIL bisection_root_search_sequencer");
        $finish;
    end

endmodule
